### hdl/bts_pkg.sv
package bts_pkg;

  localparam int unsigned DIM_W    = 8;
  localparam int unsigned ADDR_W   = 14;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COORD_W  = 17;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = COORD_W + DIM_W;
  localparam int unsigned ROW_W    = 2 * DIM_W;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned OUT_FRAC = 8;
  localparam int unsigned TEXEL_W  = 3 * CHAN_W;
  localparam int unsigned CORNERS  = 4;
  localparam int unsigned CNT_W    = 2;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;
  localparam logic [DIM_W-1:0]   DIM_RESET = 8'd128;
  localparam logic [CNT_W-1:0]   CORNER_FIRST = 2'd0;
  localparam logic [CNT_W-1:0]   CORNER_LAST  = 2'd3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic CFG_TEX_WIDTH  = 1'b0;
  localparam logic CFG_TEX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } texel_t;

  typedef struct packed {
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] x1;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
  } corner_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } rd_ctl_t;

endpackage

### hdl/bts_ram.sv
module bts_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

### hdl/bts_prep.sv
module bts_prep #(
  parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_op_i,
  input  logic [bts_pkg::ADDR_W-1:0]    in_addr_i,
  input  bts_pkg::texel_t               in_texel_i,
  input  logic [bts_pkg::COORD_W-1:0]   u_i,
  input  logic [bts_pkg::COORD_W-1:0]   v_i,
  input  logic [bts_pkg::DIM_W-1:0]     dim_w_i,
  input  logic [bts_pkg::DIM_W-1:0]     dim_h_i,
  input  logic                          take_i,
  output logic                          out_valid_o,
  output logic                          out_op_o,
  output logic [bts_pkg::ADDR_W-1:0]    out_addr_o,
  output bts_pkg::texel_t               out_texel_o,
  output bts_pkg::corner_t              corner_o,
  output logic [2*WEIGHT_FRAC_BITS:0]   wgt_o [bts_pkg::CORNERS]
);

  localparam int unsigned W     = WEIGHT_FRAC_BITS;
  localparam int unsigned WGT_W = 2 * W + 1;
  localparam int unsigned DW    = bts_pkg::DIM_W;

  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic s2_load;

  logic                         s1_op_q;
  logic [bts_pkg::ADDR_W-1:0]   s1_addr_q;
  bts_pkg::texel_t              s1_texel_q;
  logic [bts_pkg::PROD_W-1:0]   s1_pu_q, s1_pv_q;

  logic [bts_pkg::COORD_W-1:0]  u_sat, v_sat;
  logic [DW-1:0]                wm1, hm1;
  logic [DW-1:0]                x0, x1, y0, y1;
  logic [DW:0]                  x1_sum, y1_sum;
  logic [bts_pkg::FRAC_W-1:0]   xf, yf;
  logic [W-1:0]                 s_w, t_w;
  logic [W:0]                   one_s, one_t, s_e, t_e;

  assign s2_load    = s1_v_q && (!s2_v_q || take_i);
  assign in_ready_o = !s1_v_q || s2_load;

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_valid_i && in_ready_o) begin
      s1_v_d = 1'b1;
    end else if (s2_load) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_v_q;
    if (s2_load) begin
      s2_v_d = 1'b1;
    end else if (take_i) begin
      s2_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  assign wm1   = dim_w_i - 1'b1;
  assign hm1   = dim_h_i - 1'b1;
  assign u_sat = (u_i > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : u_i;
  assign v_sat = (v_i > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : v_i;

  // coordinate scaling
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= in_op_i;
      s1_addr_q  <= in_addr_i;
      s1_texel_q <= in_texel_i;
      s1_pu_q    <= bts_pkg::PROD_W'(u_sat) * bts_pkg::PROD_W'(wm1);
      s1_pv_q    <= bts_pkg::PROD_W'(v_sat) * bts_pkg::PROD_W'(hm1);
    end
  end

  // floor, ceiling neighbour and weights
  assign x0     = s1_pu_q[bts_pkg::FRAC_W +: DW];
  assign y0     = s1_pv_q[bts_pkg::FRAC_W +: DW];
  assign xf     = s1_pu_q[bts_pkg::FRAC_W-1:0];
  assign yf     = s1_pv_q[bts_pkg::FRAC_W-1:0];
  assign x1_sum = {1'b0, x0} + (DW+1)'(xf != '0);
  assign y1_sum = {1'b0, y0} + (DW+1)'(yf != '0);
  assign x1     = (x1_sum > {1'b0, wm1}) ? wm1 : x1_sum[DW-1:0];
  assign y1     = (y1_sum > {1'b0, hm1}) ? hm1 : y1_sum[DW-1:0];
  assign s_w    = xf[bts_pkg::FRAC_W-1 -: W];
  assign t_w    = yf[bts_pkg::FRAC_W-1 -: W];
  assign s_e    = {1'b0, s_w};
  assign t_e    = {1'b0, t_w};
  assign one_s  = {1'b1, {W{1'b0}}} - s_e;
  assign one_t  = {1'b1, {W{1'b0}}} - t_e;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_op_o      <= s1_op_q;
      out_addr_o    <= s1_addr_q;
      out_texel_o   <= s1_texel_q;
      corner_o.x0   <= x0;
      corner_o.x1   <= x1;
      corner_o.row0 <= bts_pkg::ROW_W'(y0) * bts_pkg::ROW_W'(dim_w_i);
      corner_o.row1 <= bts_pkg::ROW_W'(y1) * bts_pkg::ROW_W'(dim_w_i);
      wgt_o[0]      <= WGT_W'(WGT_W'(one_s) * WGT_W'(one_t));
      wgt_o[1]      <= WGT_W'(WGT_W'(s_e) * WGT_W'(one_t));
      wgt_o[2]      <= WGT_W'(WGT_W'(one_s) * WGT_W'(t_e));
      wgt_o[3]      <= WGT_W'(WGT_W'(s_e) * WGT_W'(t_e));
    end
  end

  assign out_valid_o = s2_v_q;

endmodule

### hdl/bts_blend.sv
module bts_blend #(
  parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  bts_pkg::rd_ctl_t            rd_i,
  input  logic [2*WEIGHT_FRAC_BITS:0] wgt_i,
  input  bts_pkg::texel_t             texel_i,
  output logic                        res_valid_o,
  output bts_pkg::pixel_t             res_o
);

  localparam int unsigned W     = WEIGHT_FRAC_BITS;
  localparam int unsigned ACC_W = 2 * W + bts_pkg::CHAN_W;
  localparam int unsigned SHIFT = 2 * W - bts_pkg::OUT_FRAC;

  logic [bts_pkg::CHAN_W-1:0] chan [3];
  logic [ACC_W-1:0]           acc_q [3];
  logic [ACC_W-1:0]           sum [3];

  assign chan[0] = texel_i.red;
  assign chan[1] = texel_i.green;
  assign chan[2] = texel_i.blue;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [ACC_W-1:0] prod;
    assign prod   = ACC_W'(ACC_W'(chan[c]) * ACC_W'(wgt_i));
    assign sum[c] = (rd_i.first ? '0 : acc_q[c]) + prod;

    always_ff @(posedge clk_i) begin
      if (rd_i.valid) begin
        acc_q[c] <= sum[c];
      end
    end
  end

  assign res_valid_o = rd_i.valid && rd_i.last;
  assign res_o.red   = sum[0][SHIFT +: bts_pkg::OUT_W];
  assign res_o.green = sum[1][SHIFT +: bts_pkg::OUT_W];
  assign res_o.blue  = sum[2][SHIFT +: bts_pkg::OUT_W];

endmodule

### hdl/bilinear_texture_sampler_core.sv
// sample word: one corner texel read per cycle from the single-port texel ram, last read waits for buffer room
// load word: one texel ram write
// output side: two-word result buffer, input keeps flowing while a result waits and the buffer has room
// reset: control and dimension registers cleared (dimensions to 128), texel ram not cleared
module bilinear_texture_sampler_core #(
  parameter int unsigned MAX_WIDTH        = 128,
  parameter int unsigned MAX_HEIGHT       = 128,
  parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [71:0]                 s_axis_tdata,  // texel_address, texel_red, texel_green, texel_blue, u_coord, v_coord
  input  logic                        s_axis_tuser,  // operation
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,  // red_out, green_out, blue_out
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [bts_pkg::DIM_W-1:0]   cfg_wdata_i
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WGT_W = 2 * WEIGHT_FRAC_BITS + 1;
  localparam int unsigned DW    = bts_pkg::DIM_W;

  logic [DW-1:0] tex_w_q, tex_h_q;
  logic [DW-1:0] dim_w, dim_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= bts_pkg::DIM_RESET;
      tex_h_q <= bts_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bts_pkg::CFG_TEX_WIDTH:  tex_w_q <= cfg_wdata_i;
        bts_pkg::CFG_TEX_HEIGHT: tex_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (tex_w_q == '0) begin
      dim_w = DW'(1);
    end else if (32'(tex_w_q) > MAX_WIDTH) begin
      dim_w = DW'(MAX_WIDTH);
    end else begin
      dim_w = tex_w_q;
    end
    priority if (tex_h_q == '0) begin
      dim_h = DW'(1);
    end else if (32'(tex_h_q) > MAX_HEIGHT) begin
      dim_h = DW'(MAX_HEIGHT);
    end else begin
      dim_h = tex_h_q;
    end
  end

  bts_pkg::texel_t            in_texel;
  logic                       cur_v, cur_op, take;
  logic [bts_pkg::ADDR_W-1:0] cur_addr;
  bts_pkg::texel_t            cur_texel;
  bts_pkg::corner_t           corner;
  logic [WGT_W-1:0]           wgt [bts_pkg::CORNERS];

  assign in_texel.red   = s_axis_tdata[21:14];
  assign in_texel.green = s_axis_tdata[29:22];
  assign in_texel.blue  = s_axis_tdata[37:30];

  bts_prep #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[13:0]),
    .in_texel_i  (in_texel),
    .u_i         (s_axis_tdata[54:38]),
    .v_i         (s_axis_tdata[71:55]),
    .dim_w_i     (dim_w),
    .dim_h_i     (dim_h),
    .take_i      (take),
    .out_valid_o (cur_v),
    .out_op_o    (cur_op),
    .out_addr_o  (cur_addr),
    .out_texel_o (cur_texel),
    .corner_o    (corner),
    .wgt_o       (wgt)
  );

  // corner read sequencer
  logic [bts_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           issue, room, ram_we, ram_en, in_range;
  logic [bts_pkg::ROW_W:0]        rd_idx;
  logic [AW-1:0]                  ram_addr;
  logic [bts_pkg::TEXEL_W-1:0]    ram_rdata;
  bts_pkg::rd_ctl_t               rd_q, rd_d;
  logic [WGT_W-1:0]               rd_wgt_q;
  logic [bts_pkg::FIFO_CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;
  logic                           pend;

  assign pend  = rd_q.valid && rd_q.last;
  assign room  = ({1'b0, fifo_cnt_q} + 3'(pend)) < 3'd2;
  assign issue = cur_v && (cur_op == bts_pkg::OP_SAMPLE)
                 && ((cnt_q != bts_pkg::CORNER_LAST) || room);
  assign take  = cur_v && ((cur_op == bts_pkg::OP_WRITE)
                 || ((cnt_q == bts_pkg::CORNER_LAST) && room));

  assign in_range = 32'(cur_addr) < DEPTH;
  assign ram_we   = cur_v && (cur_op == bts_pkg::OP_WRITE) && in_range;
  assign ram_en   = issue || ram_we;
  assign rd_idx   = (bts_pkg::ROW_W+1)'(cnt_q[1] ? corner.row1 : corner.row0)
                  + (bts_pkg::ROW_W+1)'(cnt_q[0] ? corner.x1 : corner.x0);
  assign ram_addr = issue ? AW'(rd_idx) : AW'(cur_addr);

  assign cnt_d      = issue ? cnt_q + 1'b1 : cnt_q;
  assign rd_d.valid = issue;
  assign rd_d.first = cnt_q == bts_pkg::CORNER_FIRST;
  assign rd_d.last  = cnt_q == bts_pkg::CORNER_LAST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_wgt_q <= wgt[cnt_q];
    end
  end

  bts_ram #(
    .WIDTH(bts_pkg::TEXEL_W),
    .DEPTH(DEPTH)
  ) u_texel_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cur_texel),
    .rdata_o (ram_rdata)
  );

  logic            res_valid;
  bts_pkg::pixel_t res;

  bts_blend #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rd_i        (rd_q),
    .wgt_i       (rd_wgt_q),
    .texel_i     (bts_pkg::texel_t'(ram_rdata)),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffer
  bts_pkg::pixel_t fifo_q [2];
  bts_pkg::pixel_t fifo_d [2];
  logic            pop;
  logic [bts_pkg::FIFO_CNT_W-1:0] wr_slot;

  assign pop     = (fifo_cnt_q != '0) && m_axis_tready;
  assign wr_slot = fifo_cnt_q - bts_pkg::FIFO_CNT_W'(pop);

  always_comb begin
    fifo_d = fifo_q;
    if (pop) begin
      fifo_d[0] = fifo_q[1];
    end
    if (res_valid) begin
      fifo_d[wr_slot[0]] = res;
    end
    fifo_cnt_d = fifo_cnt_q + bts_pkg::FIFO_CNT_W'(res_valid)
               - bts_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = fifo_q[0];

endmodule

### hdl/bts_checker.sv
module bts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic [3:0] open_q;
  logic       s_take, m_take;

  assign s_take = s_axis_tvalid && s_axis_tready && (s_axis_tuser == bts_pkg::OP_SAMPLE);
  assign m_take = m_axis_tvalid && m_axis_tready;

  // samples accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 4'(s_take) - 4'(m_take);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'hFF00) && (m_axis_tdata[31:16] <= 16'hFF00)
                      && (m_axis_tdata[47:32] <= 16'hFF00))
    else $error("blended channel above full scale");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != '0)
    else $error("result word without a pending sample");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'd4)
    else $error("more samples in flight than the pipeline holds");

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (.*);

### test/bts_sample_checker.sv
`timescale 1ns / 100ps

module bts_sample_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  // texel_address, texel_red, texel_green, texel_blue, u_coord, v_coord
  input  logic [71:0]               s_axis_tdata,
  input  logic                      s_axis_tuser,  // operation
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [47:0]               m_axis_tdata,  // red_out, green_out, blue_out
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [bts_pkg::DIM_W-1:0] cfg_wdata_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  localparam int unsigned MAX_W   = 128;
  localparam int unsigned MAX_H   = 128;
  localparam int unsigned WT_BITS = 8;
  localparam int unsigned DEPTH   = MAX_W * MAX_H;

  bts_pkg::texel_t           texels [DEPTH];
  bts_pkg::pixel_t           expected_pixels [$];
  logic [bts_pkg::DIM_W-1:0] tex_width;
  logic [bts_pkg::DIM_W-1:0] tex_height;
  int unsigned               fails;

  function automatic int unsigned eff_dim(input logic [bts_pkg::DIM_W-1:0] d,
                                          input int unsigned maxv);
    if (d == 0) return 1;
    if (d > maxv) return maxv;
    return d;
  endfunction

  function automatic void split_coord(input logic [bts_pkg::COORD_W-1:0] c,
                                      input int unsigned dim,
                                      output int unsigned lo, output int unsigned hi,
                                      output int unsigned wt);
    int unsigned cc;
    int unsigned sc;
    cc = c;
    if (cc > bts_pkg::COORD_ONE) cc = bts_pkg::COORD_ONE;
    sc = cc * (dim - 1);
    lo = sc >> bts_pkg::FRAC_W;
    hi = lo + (((sc & 32'hFFFF) != 0) ? 1 : 0);
    if (hi > dim - 1) hi = dim - 1;
    wt = (sc & 32'hFFFF) >> (bts_pkg::FRAC_W - WT_BITS);
  endfunction

  function automatic bts_pkg::pixel_t blend_texels(input logic [bts_pkg::COORD_W-1:0] u,
                                                   input logic [bts_pkg::COORD_W-1:0] v);
    int unsigned     w, h, x0, x1, y0, y1, s, t, one;
    int unsigned     acc_r, acc_g, acc_b;
    int unsigned     wt [bts_pkg::CORNERS];
    bts_pkg::texel_t c [bts_pkg::CORNERS];
    bts_pkg::pixel_t px;
    w = eff_dim(tex_width, MAX_W);
    h = eff_dim(tex_height, MAX_H);
    split_coord(u, w, x0, x1, s);
    split_coord(v, h, y0, y1, t);
    c[0] = texels[x0 + y0 * w];
    c[1] = texels[x1 + y0 * w];
    c[2] = texels[x0 + y1 * w];
    c[3] = texels[x1 + y1 * w];
    one = 1 << WT_BITS;
    wt[0] = (one - s) * (one - t);
    wt[1] = s * (one - t);
    wt[2] = (one - s) * t;
    wt[3] = s * t;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int k = 0; k < bts_pkg::CORNERS; k++) begin
      acc_r += c[k].red * wt[k];
      acc_g += c[k].green * wt[k];
      acc_b += c[k].blue * wt[k];
    end
    px.red   = bts_pkg::OUT_W'(acc_r >> (2 * WT_BITS - bts_pkg::OUT_FRAC));
    px.green = bts_pkg::OUT_W'(acc_g >> (2 * WT_BITS - bts_pkg::OUT_FRAC));
    px.blue  = bts_pkg::OUT_W'(acc_b >> (2 * WT_BITS - bts_pkg::OUT_FRAC));
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bts_pkg::pixel_t want;
    bts_pkg::pixel_t got;
    logic [15:0]     want_ch [3];
    logic [15:0]     got_ch [3];
    string           ch_name [3];
    bts_pkg::texel_t color;
    if (!rst_ni) begin
      expected_pixels.delete();
      tex_width  = bts_pkg::DIM_RESET;
      tex_height = bts_pkg::DIM_RESET;
      fails      = 0;
    end else begin
      ch_name = '{"red_out", "green_out", "blue_out"};
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bts_pkg::CFG_TEX_WIDTH: begin
            tex_width = cfg_wdata_i;
          end
          bts_pkg::CFG_TEX_HEIGHT: begin
            tex_height = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          want_ch = '{want.red, want.green, want.blue};
          got_ch  = '{got.red, got.green, got.blue};
          for (int k = 0; k < 3; k++) begin
            if (got_ch[k] !== want_ch[k]) begin
              $error("%s expected %0d actual %0d", ch_name[k], want_ch[k], got_ch[k]);
              fails++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == bts_pkg::OP_WRITE) begin
          color.red   = s_axis_tdata[21:14];
          color.green = s_axis_tdata[29:22];
          color.blue  = s_axis_tdata[37:30];
          texels[s_axis_tdata[13:0]] = color;
        end else begin
          expected_pixels.push_back(blend_texels(s_axis_tdata[54:38], s_axis_tdata[71:55]));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_pixels.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAX_DIM = 128;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned LIMIT   = 400000;
  localparam int unsigned DRAIN   = 20;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // texel_address, texel_red, texel_green, texel_blue, u_coord, v_coord
  logic [71:0]                 s_axis_tdata = '0;
  logic                        s_axis_tuser = bts_pkg::OP_WRITE;  // operation
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [47:0]                 m_axis_tdata;  // red_out, green_out, blue_out
  logic                        cfg_we_i = 1'b0;
  logic                        cfg_addr_i = bts_pkg::CFG_TEX_WIDTH;
  logic [bts_pkg::DIM_W-1:0]   cfg_wdata_i = '0;
  int unsigned                 fail_count;
  int unsigned                 pending;

  logic [bts_pkg::DIM_W-1:0]   cur_w = bts_pkg::DIM_RESET;
  logic [bts_pkg::DIM_W-1:0]   cur_h = bts_pkg::DIM_RESET;
  bit                          loaded [DEPTH];
  int                          burst_left = 0;

  bilinear_texture_sampler_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bts_sample_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int mode = 0;
    int left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 80);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (left % 3 != 0);
      endcase
    end
  end

  function automatic int unsigned eff_dim(input logic [bts_pkg::DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic void cell_span(input logic [bts_pkg::COORD_W-1:0] c,
                                    input int unsigned dim,
                                    output int unsigned lo, output int unsigned hi);
    int unsigned cc;
    int unsigned sc;
    cc = c;
    if (cc > bts_pkg::COORD_ONE) cc = bts_pkg::COORD_ONE;
    sc = cc * (dim - 1);
    lo = sc >> bts_pkg::FRAC_W;
    hi = lo + (((sc & 32'hFFFF) != 0) ? 1 : 0);
    if (hi > dim - 1) hi = dim - 1;
  endfunction

  function automatic bts_pkg::texel_t random_texel();
    return bts_pkg::texel_t'(bts_pkg::TEXEL_W'($urandom));
  endfunction

  function automatic logic [bts_pkg::COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bts_pkg::COORD_ONE;
      2: return bts_pkg::COORD_W'($urandom_range(65537, 131071));
      default: return bts_pkg::COORD_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic put_word(input logic op, input logic [bts_pkg::ADDR_W-1:0] addr,
                          input bts_pkg::texel_t color,
                          input logic [bts_pkg::COORD_W-1:0] u,
                          input logic [bts_pkg::COORD_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {v, u, color.blue, color.green, color.red, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic load_texel(input logic [bts_pkg::ADDR_W-1:0] addr,
                            input bts_pkg::texel_t color);
    put_word(bts_pkg::OP_WRITE, addr, color, bts_pkg::COORD_W'($urandom),
             bts_pkg::COORD_W'($urandom));
    loaded[addr] = 1'b1;
  endtask

  // corners that were never loaded get a texel first
  task automatic sample_at(input logic [bts_pkg::COORD_W-1:0] u,
                           input logic [bts_pkg::COORD_W-1:0] v);
    int unsigned w, h, x0, x1, y0, y1;
    int unsigned corner [bts_pkg::CORNERS];
    w = eff_dim(cur_w);
    h = eff_dim(cur_h);
    cell_span(u, w, x0, x1);
    cell_span(v, h, y0, y1);
    corner[0] = x0 + y0 * w;
    corner[1] = x1 + y0 * w;
    corner[2] = x0 + y1 * w;
    corner[3] = x1 + y1 * w;
    for (int k = 0; k < bts_pkg::CORNERS; k++) begin
      if (!loaded[corner[k]]) load_texel(bts_pkg::ADDR_W'(corner[k]), random_texel());
    end
    put_word(bts_pkg::OP_SAMPLE, bts_pkg::ADDR_W'($urandom), random_texel(), u, v);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic idx, input logic [bts_pkg::DIM_W-1:0] value);
    drain_results();
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bts_pkg::CFG_TEX_WIDTH) cur_w = value;
    else cur_h = value;
  endtask

  task automatic set_dims(input logic [bts_pkg::DIM_W-1:0] w,
                          input logic [bts_pkg::DIM_W-1:0] h);
    write_reg(bts_pkg::CFG_TEX_WIDTH, w);
    write_reg(bts_pkg::CFG_TEX_HEIGHT, h);
  endtask

  task automatic run_random(input int n, input bit hold_midway);
    int unsigned span;
    for (int i = 0; i < n; i++) begin
      if (hold_midway && i == n / 2) drain_results();
      if ($urandom_range(0, 99) < 35) begin
        span = eff_dim(cur_w) * eff_dim(cur_h);
        if ($urandom_range(0, 1) == 1) begin
          load_texel(bts_pkg::ADDR_W'($urandom_range(0, span - 1)), random_texel());
        end else begin
          load_texel(bts_pkg::ADDR_W'($urandom), random_texel());
        end
      end else begin
        sample_at(random_coord(), random_coord());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes at the reset size
    load_texel(14'd0, '{red: 8'd0, green: 8'd0, blue: 8'd0});
    load_texel(14'd16383, '{red: 8'd255, green: 8'd255, blue: 8'd255});
    load_texel(14'd1, '{red: 8'd255, green: 8'd0, blue: 8'd255});
    load_texel(14'd128, '{red: 8'd0, green: 8'd255, blue: 8'd0});
    sample_at('0, '0);
    sample_at(bts_pkg::COORD_ONE, bts_pkg::COORD_ONE);
    sample_at(17'h1FFFF, 17'h1FFFF);
    sample_at('0, 17'h1FFFF);
    sample_at(17'd32768, 17'd32768);
    sample_at(17'd516, 17'd516);
    sample_at(17'd65535, 17'd65535);

    // exact grid points give a zero fraction; one off-grid u follows
    set_dims(8'd3, 8'd5);
    sample_at(17'd32768, 17'd16384);
    sample_at(17'd32768, 17'd49152);
    sample_at(17'd40000, 17'd16384);
    run_random(30, 1'b0);

    set_dims(8'd1, 8'd1);
    run_random(20, 1'b0);
    set_dims(8'd0, 8'd255);
    run_random(30, 1'b0);
    set_dims(8'd2, 8'd2);
    run_random(20, 1'b0);
    set_dims(8'd255, 8'd0);
    run_random(30, 1'b0);
    repeat (3) begin
      set_dims(bts_pkg::DIM_W'($urandom_range(1, 128)),
               bts_pkg::DIM_W'($urandom_range(1, 128)));
      run_random(16, 1'b0);
    end
    set_dims(8'd128, 8'd128);
    run_random(16, 1'b1);

    drain_results();
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
